FILE: src/rjq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_pkg - shared types and constants of the retry job queue scheduler
// Sizes, command and event codes, register indexes and the structs that
// pass between the sequencer, the entry memory and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rjq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int RUN_LIMIT   = 16;
	localparam int MAX_RES     = 32;

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W  = $clog2(RUN_LIMIT + 1);
	localparam int RES_W  = $clog2(MAX_RES + 1);

	localparam int TAG_W     = 32;
	localparam int LCH_W     = 4;
	localparam int TIME_W    = 48;
	localparam int BASE_W    = 24;
	localparam int RT_W      = 32;
	localparam int MAX_SHIFT = (1 << LCH_W) - 2;
	localparam int DELAY_W   = BASE_W + MAX_SHIFT;

	localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

	// commands
	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_DONE = 2'd2;

	// event kinds
	localparam logic [2:0] EV_QUEUED   = 3'd0;
	localparam logic [2:0] EV_EVICTED  = 3'd1;
	localparam logic [2:0] EV_LAUNCHED = 3'd2;
	localparam logic [2:0] EV_RETRY    = 3'd3;
	localparam logic [2:0] EV_DONE_OK  = 3'd4;
	localparam logic [2:0] EV_FAILED   = 3'd5;
	localparam logic [2:0] EV_TIMEOUT  = 3'd6;
	localparam logic [2:0] EV_UNKNOWN  = 3'd7;

	// register indexes
	localparam logic [1:0] REG_MAX_RUNNING  = 2'd0;
	localparam logic [1:0] REG_MAX_LAUNCHES = 2'd1;
	localparam logic [1:0] REG_RETRY_BASE   = 2'd2;
	localparam logic [1:0] REG_MAX_RUNTIME  = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [LCH_W-1:0]  launches;
		logic [TIME_W-1:0] when_ms;
		logic [SLOT_W-1:0] prev;
		logic [SLOT_W-1:0] next;
	} entry_t;

	typedef struct packed {
		logic tag;
		logic launches;
		logic when_ms;
		logic prev;
		logic next;
	} entry_wen_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [7:0]       slot;
		logic [TAG_W-1:0] tag;
		logic [LCH_W-1:0] launches;
		logic [7:0]       exit_code;
		logic [6:0]       sig;
	} event_t;

	typedef struct packed {
		logic [4:0]        max_running;
		logic [LCH_W-1:0]  max_launches;
		logic [BASE_W-1:0] retry_base_ms;
		logic [RT_W-1:0]   max_runtime_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [TAG_W-1:0]  job_tag;
		logic [TIME_W-1:0] now_ms;
		logic [7:0]        slot;
		logic [7:0]        exit_code;
		logic [6:0]        signal_num;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic fin;
	} res_ctl_t;

endpackage

`default_nettype wire

FILE: src/rjq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_mem - entry memory
// One write port with field enables, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rjq_mem import rjq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              re,
	input  wire logic [SLOT_W-1:0] raddr,
	output entry_t                 rdata,
	input  wire entry_wen_t        wen,
	input  wire logic [SLOT_W-1:0] waddr,
	input  wire entry_t            wdata
);

	entry_t entry_mem_q [QUEUE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wen.tag)      entry_mem_q[waddr].tag      <= wdata.tag;
		if (wen.launches) entry_mem_q[waddr].launches <= wdata.launches;
		if (wen.when_ms)  entry_mem_q[waddr].when_ms  <= wdata.when_ms;
		if (wen.prev)     entry_mem_q[waddr].prev     <= wdata.prev;
		if (wen.next)     entry_mem_q[waddr].next     <= wdata.next;
		if (re)           rdata_q <= entry_mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/rjq_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_out - result stage
// Hold one result back until the next one or the end of the command is known,
// so that the final result can carry its last flag, then register it out.
// ----------------------------------------------------------------------------
`default_nettype none

module rjq_out import rjq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire res_ctl_t ctl,
	input  wire event_t   ev,
	output logic          rdy,
	output logic          out_valid,
	input  wire logic     out_ready,
	output event_t        out_ev,
	output logic          out_last
);

	logic   pend_v_q;
	event_t pend_q;
	logic   out_v_q;
	event_t out_q;
	logic   last_q;
	logic   move;

	assign rdy  = !pend_v_q || !out_v_q || out_ready;
	assign move = (ctl.push || ctl.fin) && pend_v_q && rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			if (ctl.push) pend_v_q <= 1'b1;
			else if (ctl.fin && rdy) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q  <= pend_q;
			last_q <= ctl.fin;
		end
		if (ctl.push) pend_q <= ev;
	end

	assign out_valid = out_v_q;
	assign out_ev    = out_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

FILE: src/rjq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjq_ctrl - command sequencer
// Walk the age-ordered entry list in the memory, launch, time out, evict,
// retry and remove jobs; keep valid and running flags and the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module rjq_ctrl import rjq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire cmd_t              cmd,
	output res_ctl_t               res_ctl,
	output event_t                 res_ev,
	input  wire logic              res_rdy,
	output logic                   mem_re,
	output logic      [SLOT_W-1:0] mem_raddr,
	input  wire entry_t            mem_rdata,
	output entry_wen_t             mem_wen,
	output logic      [SLOT_W-1:0] mem_waddr,
	output entry_t                 mem_wdata
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_SCAN     = 5'd1;
	localparam logic [4:0] S_EV_RD    = 5'd2;
	localparam logic [4:0] S_EV_CHK   = 5'd3;
	localparam logic [4:0] S_UNLINK   = 5'd4;
	localparam logic [4:0] S_UNLINK2  = 5'd5;
	localparam logic [4:0] S_APPEND1  = 5'd6;
	localparam logic [4:0] S_APPEND2  = 5'd7;
	localparam logic [4:0] S_QUEUED   = 5'd8;
	localparam logic [4:0] S_LA_RD    = 5'd9;
	localparam logic [4:0] S_LA_CHK   = 5'd10;
	localparam logic [4:0] S_TO_RD    = 5'd11;
	localparam logic [4:0] S_TO_CHK   = 5'd12;
	localparam logic [4:0] S_CO_RD    = 5'd13;
	localparam logic [4:0] S_CO_CHK   = 5'd14;
	localparam logic [4:0] S_CO_RETRY = 5'd15;
	localparam logic [4:0] S_UNK      = 5'd16;
	localparam logic [4:0] S_FIN      = 5'd17;

	logic [4:0]         state_q, state_d;
	cmd_t               cmd_q, cmd_d;
	logic [SLOT_W-1:0]  cur_q, cur_d;
	logic [SLOT_W-1:0]  pick_q, pick_d;
	logic [SLOT_W-1:0]  head_q, head_d;
	logic [SLOT_W-1:0]  tail_q, tail_d;
	logic [SLOT_W-1:0]  lnk_prev_q, lnk_prev_d;
	logic [SLOT_W-1:0]  lnk_next_q, lnk_next_d;
	logic [SLOT_W-1:0]  scan_q, scan_d;
	logic [TAG_W-1:0]   ent_tag_q, ent_tag_d;
	logic [LCH_W-1:0]   ent_lch_q, ent_lch_d;
	logic [DELAY_W-1:0] delay_q, delay_d;
	logic               unl_append_q, unl_append_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [CNT_W-1:0]   run_cnt_q, run_cnt_d;
	logic [RES_W-1:0]   res_cnt_q, res_cnt_d;
	logic               valid_q   [QUEUE_DEPTH];
	logic               running_q [QUEUE_DEPTH];

	logic              vld_set, vld_clr, run_set, run_clr;
	logic [SLOT_W-1:0] flag_idx;
	logic              want, go;
	event_t            ev;

	logic [CNT_W-1:0]   lim;
	logic [SLOT_W-1:0]  cmd_idx;
	logic               in_range;
	logic               launch_ok, timed_out, retry_req, is_fail;
	logic [LCH_W-1:0]   lch_inc, shift;
	logic [TIME_W-1:0]  elapsed, retry_time;
	logic [DELAY_W-1:0] delay;
	logic [TIME_W:0]    sum;
	logic               la_more;

	function automatic event_t mk_ev(input logic [2:0] kind, input logic [7:0] slot,
			input logic [TAG_W-1:0] tag, input logic [LCH_W-1:0] lch,
			input logic [7:0] ex, input logic [6:0] sig);
		event_t e;
		e.kind      = kind;
		e.slot      = slot;
		e.tag       = tag;
		e.launches  = lch;
		e.exit_code = ex;
		e.sig       = sig;
		return e;
	endfunction

	always_comb begin
		if ({2'b00, cfg.max_running} > 7'(RUN_LIMIT)) lim = CNT_W'(RUN_LIMIT);
		else lim = CNT_W'(cfg.max_running);
	end

	assign cmd_idx  = SLOT_W'(cmd.slot);
	assign in_range = {24'd0, cmd.slot} < 32'(QUEUE_DEPTH);

	assign launch_ok = !running_q[cur_q] &&
		(mem_rdata.when_ms == '0 || mem_rdata.when_ms <= cmd_q.now_ms);
	assign lch_inc   = (mem_rdata.launches == '1) ? mem_rdata.launches
		: mem_rdata.launches + 1'b1;
	assign elapsed   = cmd_q.now_ms - mem_rdata.when_ms;
	assign timed_out = running_q[cur_q] && (cmd_q.now_ms > mem_rdata.when_ms) &&
		(elapsed > TIME_W'(cfg.max_runtime_ms));
	assign retry_req = (cmd_q.signal_num != 7'd0 || cmd_q.exit_code == 8'd1) &&
		(mem_rdata.launches < cfg.max_launches);
	assign is_fail   = (cmd_q.signal_num != 7'd0) || (cmd_q.exit_code != 8'd0);
	assign shift     = (mem_rdata.launches == '0) ? '0 : mem_rdata.launches - 1'b1;
	assign delay     = DELAY_W'(cfg.retry_base_ms) << shift;
	assign sum        = {1'b0, cmd_q.now_ms} + (TIME_W + 1)'(delay_q);
	assign retry_time = sum[TIME_W] ? MAX_TIME : sum[TIME_W-1:0];

	assign go = !want || res_rdy;

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		cur_d        = cur_q;
		pick_d       = pick_q;
		head_d       = head_q;
		tail_d       = tail_q;
		lnk_prev_d   = lnk_prev_q;
		lnk_next_d   = lnk_next_q;
		scan_d       = scan_q;
		ent_tag_d    = ent_tag_q;
		ent_lch_d    = ent_lch_q;
		delay_d      = delay_q;
		unl_append_d = unl_append_q;
		fill_d       = fill_q;
		run_cnt_d    = run_cnt_q;
		res_cnt_d    = res_cnt_q;
		vld_set      = 1'b0;
		vld_clr      = 1'b0;
		run_set      = 1'b0;
		run_clr      = 1'b0;
		flag_idx     = cur_q;
		want         = 1'b0;
		ev           = '0;
		res_ctl.fin  = 1'b0;
		cmd_ready    = 1'b0;
		mem_re       = 1'b0;
		mem_raddr    = cur_q;
		mem_wen      = '0;
		mem_waddr    = cur_q;
		mem_wdata    = '0;
		la_more      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cmd_d     = cmd;
					res_cnt_d = '0;
					unique case (cmd.command)
						CMD_ENQ: begin
							if (fill_q != FILL_W'(QUEUE_DEPTH)) begin
								scan_d  = '0;
								state_d = S_SCAN;
							end else begin
								cur_d   = head_q;
								state_d = S_EV_RD;
							end
						end
						CMD_TICK: begin
							cur_d = head_q;
							if (fill_q == '0) state_d = S_FIN;
							else if (run_cnt_q < lim) state_d = S_LA_RD;
							else state_d = S_TO_RD;
						end
						CMD_DONE: begin
							if (!in_range || !valid_q[cmd_idx] || !running_q[cmd_idx]) begin
								state_d = S_UNK;
							end else begin
								cur_d   = cmd_idx;
								state_d = S_CO_RD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				if (!valid_q[scan_q]) begin
					pick_d  = scan_q;
					state_d = S_APPEND1;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			S_EV_RD: begin
				mem_re  = 1'b1;
				state_d = S_EV_CHK;
			end
			S_EV_CHK: begin
				if (!running_q[cur_q]) begin
					want = 1'b1;
					ev   = mk_ev(EV_EVICTED, 8'(cur_q), mem_rdata.tag, mem_rdata.launches,
						8'd0, 7'd0);
					if (go) begin
						pick_d       = cur_q;
						lnk_prev_d   = mem_rdata.prev;
						lnk_next_d   = mem_rdata.next;
						unl_append_d = 1'b1;
						res_cnt_d    = res_cnt_q + 1'b1;
						state_d      = S_UNLINK;
					end
				end else if (cur_q == tail_q) begin
					// nothing waiting: drop the new job
					want = 1'b1;
					ev   = mk_ev(EV_EVICTED, 8'd0, cmd_q.job_tag, '0, 8'd0, 7'd0);
					if (go) begin
						res_cnt_d = res_cnt_q + 1'b1;
						state_d   = S_FIN;
					end
				end else begin
					cur_d   = mem_rdata.next;
					state_d = S_EV_RD;
				end
			end
			S_UNLINK: begin
				vld_clr  = 1'b1;
				flag_idx = pick_q;
				fill_d   = fill_q - 1'b1;
				state_d  = unl_append_q ? S_APPEND1 : S_FIN;
				if (pick_q == head_q && pick_q == tail_q) begin
					head_d = head_q;
				end else if (pick_q == head_q) begin
					head_d = lnk_next_q;
				end else if (pick_q == tail_q) begin
					tail_d = lnk_prev_q;
				end else begin
					mem_wen.next   = 1'b1;
					mem_waddr      = lnk_prev_q;
					mem_wdata.next = lnk_next_q;
					state_d        = S_UNLINK2;
				end
			end
			S_UNLINK2: begin
				mem_wen.prev   = 1'b1;
				mem_waddr      = lnk_next_q;
				mem_wdata.prev = lnk_prev_q;
				state_d        = unl_append_q ? S_APPEND1 : S_FIN;
			end
			S_APPEND1: begin
				mem_wen.tag        = 1'b1;
				mem_wen.launches   = 1'b1;
				mem_wen.when_ms    = 1'b1;
				mem_wen.prev       = 1'b1;
				mem_waddr          = pick_q;
				mem_wdata.tag      = cmd_q.job_tag;
				mem_wdata.prev     = tail_q;
				vld_set            = 1'b1;
				run_clr            = 1'b1;
				flag_idx           = pick_q;
				fill_d             = fill_q + 1'b1;
				if (fill_q == '0) begin
					head_d  = pick_q;
					tail_d  = pick_q;
					state_d = S_QUEUED;
				end else begin
					state_d = S_APPEND2;
				end
			end
			S_APPEND2: begin
				mem_wen.next   = 1'b1;
				mem_waddr      = tail_q;
				mem_wdata.next = pick_q;
				tail_d         = pick_q;
				state_d        = S_QUEUED;
			end
			S_QUEUED: begin
				want = 1'b1;
				ev   = mk_ev(EV_QUEUED, 8'(pick_q), cmd_q.job_tag, '0, 8'd0, 7'd0);
				if (go) begin
					res_cnt_d = res_cnt_q + 1'b1;
					state_d   = S_FIN;
				end
			end
			S_LA_RD: begin
				mem_re  = 1'b1;
				state_d = S_LA_CHK;
			end
			S_LA_CHK: begin
				if (launch_ok) begin
					want = 1'b1;
					ev   = mk_ev(EV_LAUNCHED, 8'(cur_q), mem_rdata.tag, lch_inc, 8'd0, 7'd0);
				end
				if (go) begin
					if (launch_ok) begin
						mem_wen.launches   = 1'b1;
						mem_wen.when_ms    = 1'b1;
						mem_wdata.launches = lch_inc;
						mem_wdata.when_ms  = cmd_q.now_ms;
						run_set            = 1'b1;
						run_cnt_d          = run_cnt_q + 1'b1;
						res_cnt_d          = res_cnt_q + 1'b1;
					end
					la_more = (cur_q != tail_q) && (run_cnt_d < lim) &&
						(res_cnt_d < RES_W'(MAX_RES));
					if (la_more) begin
						cur_d   = mem_rdata.next;
						state_d = S_LA_RD;
					end else if (res_cnt_d < RES_W'(MAX_RES)) begin
						cur_d   = head_q;
						state_d = S_TO_RD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_TO_RD: begin
				mem_re  = 1'b1;
				state_d = S_TO_CHK;
			end
			S_TO_CHK: begin
				if (timed_out) begin
					want = 1'b1;
					ev   = mk_ev(EV_TIMEOUT, 8'(cur_q), mem_rdata.tag, mem_rdata.launches,
						8'd0, 7'd0);
				end
				if (go) begin
					if (timed_out) res_cnt_d = res_cnt_q + 1'b1;
					if (cur_q == tail_q || res_cnt_d >= RES_W'(MAX_RES)) begin
						state_d = S_FIN;
					end else begin
						cur_d   = mem_rdata.next;
						state_d = S_TO_RD;
					end
				end
			end
			S_CO_RD: begin
				mem_re  = 1'b1;
				state_d = S_CO_CHK;
			end
			S_CO_CHK: begin
				ent_tag_d  = mem_rdata.tag;
				ent_lch_d  = mem_rdata.launches;
				delay_d    = delay;
				lnk_prev_d = mem_rdata.prev;
				lnk_next_d = mem_rdata.next;
				pick_d     = cur_q;
				if (retry_req) begin
					state_d = S_CO_RETRY;
				end else begin
					want = 1'b1;
					if (is_fail) begin
						ev = mk_ev(EV_FAILED, 8'(cur_q), mem_rdata.tag, mem_rdata.launches,
							cmd_q.exit_code, cmd_q.signal_num);
					end else begin
						ev = mk_ev(EV_DONE_OK, 8'(cur_q), mem_rdata.tag, mem_rdata.launches,
							8'd0, 7'd0);
					end
					if (go) begin
						run_clr      = 1'b1;
						run_cnt_d    = (run_cnt_q != '0) ? run_cnt_q - 1'b1 : '0;
						res_cnt_d    = res_cnt_q + 1'b1;
						unl_append_d = 1'b0;
						state_d      = S_UNLINK;
					end
				end
			end
			S_CO_RETRY: begin
				want = 1'b1;
				ev   = mk_ev(EV_RETRY, 8'(cur_q), ent_tag_q, ent_lch_q, 8'd0, 7'd0);
				if (go) begin
					mem_wen.when_ms   = 1'b1;
					mem_wdata.when_ms = retry_time;
					run_clr           = 1'b1;
					run_cnt_d         = (run_cnt_q != '0) ? run_cnt_q - 1'b1 : '0;
					res_cnt_d         = res_cnt_q + 1'b1;
					state_d           = S_FIN;
				end
			end
			S_UNK: begin
				want = 1'b1;
				ev   = mk_ev(EV_UNKNOWN, cmd_q.slot, '0, '0, 8'd0, 7'd0);
				if (go) begin
					res_cnt_d = res_cnt_q + 1'b1;
					state_d   = S_FIN;
				end
			end
			S_FIN: begin
				res_ctl.fin = 1'b1;
				if (res_rdy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		res_ctl.push = want && res_rdy;
	end

	assign res_ev = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			run_cnt_q <= '0;
			res_cnt_q <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				valid_q[i]   <= 1'b0;
				running_q[i] <= 1'b0;
			end
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			fill_q    <= fill_d;
			run_cnt_q <= run_cnt_d;
			res_cnt_q <= res_cnt_d;
			if (vld_set) valid_q[flag_idx] <= 1'b1;
			else if (vld_clr) valid_q[flag_idx] <= 1'b0;
			if (run_set) running_q[flag_idx] <= 1'b1;
			else if (run_clr) running_q[flag_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		cur_q        <= cur_d;
		pick_q       <= pick_d;
		lnk_prev_q   <= lnk_prev_d;
		lnk_next_q   <= lnk_next_d;
		scan_q       <= scan_d;
		ent_tag_q    <= ent_tag_d;
		ent_lch_q    <= ent_lch_d;
		delay_q      <= delay_d;
		unl_append_q <= unl_append_d;
	end

	a_launch_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ctl.push && res_ev.kind == EV_LAUNCHED) |-> (run_cnt_q < lim))
		else $error("launch issued at the running limit");

	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctl.push |-> (res_cnt_q < RES_W'(MAX_RES)))
		else $error("too many results for one command");

	a_launch_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ctl.push && res_ev.kind == EV_LAUNCHED) |=> running_q[$past(cur_q)])
		else $error("launched entry not marked running");

endmodule

`default_nettype wire

FILE: src/retry_job_queue_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retry_job_queue_scheduler_core - bounded job queue with retries and timeouts
// Command stream in, event stream out, APB register port for the limits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction per command. tuser carries the command
//   (enqueue, tick, completion); tdata the job tag, time, slot, exit code and
//   signal. A command is taken only while the sequencer is idle.
//   Master stream: zero or more event transactions per command, tlast on the
//   final one. A command with no event produces no transaction.
//   Work per command: an enqueue with a free slot scans the occupied slots
//   below the lowest free one; an enqueue into a full queue walks entries
//   from the oldest end; a tick makes a launch pass and a timeout pass over
//   the age-ordered list; a completion reads its one entry unless its slot
//   is unknown. Each visited entry goes through a read state and then an
//   evaluate state, as the entry memory has a single read port.
//   Reset: the queue is empty at once (valid and running flags are flops), no
//   clearing pass; the limits return to their defaults.
//   Stalls: one result waits in a hold stage and one in the output register;
//   while both are full and tready is low, the sequencer freezes in place in
//   any state that has a result to hand over and in its finish state.
// ----------------------------------------------------------------------------
`default_nettype none

module retry_job_queue_scheduler_core import rjq_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: job_tag[31:0], now_ms[79:32], slot[87:80], exit_code[95:88],
	//        signal_num[102:96], zero pad[103]
	input  wire logic [103:0] s_tdata,
	// tuser: command[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata: event_slot[7:0], event_tag[39:8], launch_count[43:40],
	//        event_exit[51:44], event_signal[58:52], zero pad[63:59]
	output logic      [63:0]  m_tdata,
	// tuser: event_kind[2:0]
	output logic      [2:0]   m_tuser,
	output logic              m_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);

	// register file
	logic [4:0]        max_running_q;
	logic [LCH_W-1:0]  max_launches_q;
	logic [BASE_W-1:0] retry_base_q;
	logic [RT_W-1:0]   max_runtime_q;
	logic              cfg_wr;
	cfg_t              cfg;

	cmd_t       cmd;
	res_ctl_t   res_ctl;
	event_t     res_ev;
	logic       res_rdy;
	event_t     out_ev;
	logic       out_last;

	logic              mem_re;
	logic [SLOT_W-1:0] mem_raddr;
	entry_t            mem_rdata;
	entry_wen_t        mem_wen;
	logic [SLOT_W-1:0] mem_waddr;
	entry_t            mem_wdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// write the register on the access phase of an APB transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_running_q  <= 5'd16;
			max_launches_q <= 4'd10;
			retry_base_q   <= 24'd30000;
			max_runtime_q  <= 32'd60000;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MAX_RUNNING:  max_running_q  <= pwdata[4:0];
				REG_MAX_LAUNCHES: max_launches_q <= pwdata[LCH_W-1:0];
				REG_RETRY_BASE:   retry_base_q   <= pwdata[BASE_W-1:0];
				REG_MAX_RUNTIME:  max_runtime_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_RUNNING:  prdata = {27'd0, max_running_q};
			REG_MAX_LAUNCHES: prdata = {28'd0, max_launches_q};
			REG_RETRY_BASE:   prdata = {8'd0, retry_base_q};
			REG_MAX_RUNTIME:  prdata = max_runtime_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg.max_running    = max_running_q;
	assign cfg.max_launches   = max_launches_q;
	assign cfg.retry_base_ms  = retry_base_q;
	assign cfg.max_runtime_ms = max_runtime_q;

	// unpack the command transaction
	assign cmd.command    = s_tuser;
	assign cmd.job_tag    = s_tdata[31:0];
	assign cmd.now_ms     = s_tdata[79:32];
	assign cmd.slot       = s_tdata[87:80];
	assign cmd.exit_code  = s_tdata[95:88];
	assign cmd.signal_num = s_tdata[102:96];

	rjq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_ctl   (res_ctl),
		.res_ev    (res_ev),
		.res_rdy   (res_rdy),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_wen   (mem_wen),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	// one entry per slot: tag, launches, time and the age-order links
	rjq_mem u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.wen   (mem_wen),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	// hold the newest result until its last flag is known, then register it
	rjq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (res_ctl),
		.ev        (res_ev),
		.rdy       (res_rdy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ev    (out_ev),
		.out_last  (out_last)
	);

	// pack the event transaction
	assign m_tuser = out_ev.kind;
	assign m_tlast = out_last;
	assign m_tdata = {5'd0, out_ev.sig, out_ev.exit_code, out_ev.launches,
		out_ev.tag, out_ev.slot};

endmodule

`default_nettype wire
